// File: design/integer_to_ascii_padded_top_assert.svh
// Assertion macros used by the formatter top level.
`ifndef INTEGER_TO_ASCII_PADDED_TOP_ASSERT_SVH
`define INTEGER_TO_ASCII_PADDED_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2AP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("formatter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define I2AP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("formatter assertion failed");

`endif

// File: design/i2ap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2ap_pkg;

  localparam int VALUE_W   = 64;
  localparam int NIBBLES   = VALUE_W / 4;
  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 8;

  // Input beat layout, lowest bit first.
  localparam int VALUE_LSB = 0;
  localparam int MODE_LSB  = 64;
  localparam int PAD_LSB   = 66;
  localparam int WIDTH_LSB = 67;
  localparam int ROOM_LSB  = 74;
  localparam int FIELD7_W  = 7;

  localparam logic [1:0] MODE_DEC  = 2'd0;
  localparam logic [1:0] MODE_LHEX = 2'd1;
  localparam logic [1:0] MODE_UHEX = 2'd2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [7:0] LOWER_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };
  localparam logic [7:0] UPPER_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // What every digit cell does in a cycle.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_LOAD   = 2'd1,
    OP_DABBLE = 2'd2,
    OP_SHIFT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     serial_bit;  // value bit shifted into the lowest cell
    logic     load_hex;    // load value nibbles instead of zeros
  } cell_ctrl_t;

  typedef struct packed {
    logic [3:0] top_digit;
    logic       top_carry;
  } chain_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    return upper ? UPPER_DIGITS[d] : LOWER_DIGITS[d];
  endfunction

endpackage

`default_nettype wire

// File: design/integer_to_ascii_padded_top.sv
// Flow: a decimal beat is converted to BCD, a hex beat is loaded as nibbles; leading zero
// digits are then stripped and the pad and digit counts planned. Characters then leave
// one per cycle while the output is ready.
// One item at a time: a new beat is accepted only once the block is back in idle.
// Reset: rst is synchronous, active high; it empties the output stage and returns to idle.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_padded_top
  import i2ap_pkg::*;
#(
  parameter int MAX_DIGITS = 20,
  parameter int MAX_CHARS  = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // value[63:0], base_mode[65:64], pad_zero[66], min_width[73:67], room_left[80:74],
  // zeros above.
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // out_char[7:0].
  output logic      [M_TDATA_W-1:0] m_axis_tdata,
  output logic                      m_axis_tlast,   // last_char
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready
);

  // Counts sized from the parameters. MAX_CHARS must not be set below MAX_DIGITS, which
  // the block does not check, so that a digit count always fits in a character count.
  localparam int DW = $clog2(MAX_DIGITS + 1);
  localparam int CW = $clog2(MAX_CHARS + 1);
  localparam int BW = $clog2(VALUE_W);

  // Control flow: accept a beat, convert (decimal only), strip leading zero
  // digits, work out pad and digit counts, then emit characters if there is room.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DABBLE = 5'b00010,
    S_NORM   = 5'b00100,
    S_PLAN   = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t state, state_next;

  // Unpacked input fields.
  logic [VALUE_W-1:0]  in_value;
  logic [1:0]          in_mode;
  logic                in_pad_zero;
  logic [FIELD7_W-1:0] in_width;
  logic [FIELD7_W-1:0] in_room;

  assign in_value    = s_axis_tdata[VALUE_LSB +: VALUE_W];
  assign in_mode     = s_axis_tdata[MODE_LSB +: 2];
  assign in_pad_zero = s_axis_tdata[PAD_LSB];
  assign in_width    = s_axis_tdata[WIDTH_LSB +: FIELD7_W];
  assign in_room     = s_axis_tdata[ROOM_LSB +: FIELD7_W];

  // Per-item registers.
  logic [VALUE_W-1:0] value_sr, value_sr_next;
  logic [BW-1:0]      bit_cnt, bit_cnt_next;
  logic               upper, upper_next;
  logic [7:0]         pad_char, pad_char_next;
  logic [CW-1:0]      width, width_next;
  logic [CW-1:0]      room, room_next;
  logic [DW-1:0]      ndig, ndig_next;
  logic               ovf, ovf_next;
  logic [CW-1:0]      pads_left, pads_left_next;
  logic [DW-1:0]      shown_left, shown_left_next;

  // Output stage.
  logic [7:0] out_char, out_char_next;
  logic       out_last, out_last_next;
  logic       out_valid, out_valid_next;
  logic       out_free;

  cell_ctrl_t  ctrl;
  chain_stat_t stat;

  // Plan arithmetic, all narrow.
  logic [CW-1:0] ndig_ext;
  logic [CW-1:0] pads_raw;
  logic [CW-1:0] pads_n;
  logic [CW-1:0] rem_n;
  logic [DW-1:0] shown_n;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = out_char;
  assign m_axis_tlast  = out_last;
  assign m_axis_tvalid = out_valid;
  assign out_free      = !out_valid || m_axis_tready;

  always_comb begin
    ndig_ext = CW'(ndig);
    pads_raw = (width > ndig_ext) ? width - ndig_ext : '0;
    pads_n   = (pads_raw > room) ? room : pads_raw;
    rem_n    = room - pads_n;
    shown_n  = (rem_n > ndig_ext) ? ndig : rem_n[DW-1:0];
  end

  i2ap_chain #(
    .N_DIGITS (MAX_DIGITS)
  ) u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .value (in_value),
    .stat  (stat)
  );

  always_comb begin
    state_next      = state;
    value_sr_next   = value_sr;
    bit_cnt_next    = bit_cnt;
    upper_next      = upper;
    pad_char_next   = pad_char;
    width_next      = width;
    room_next       = room;
    ndig_next       = ndig;
    ovf_next        = ovf;
    pads_left_next  = pads_left;
    shown_left_next = shown_left;
    out_char_next   = out_char;
    out_last_next   = out_last;
    out_valid_next  = out_valid && !m_axis_tready;
    ctrl.op         = OP_HOLD;
    ctrl.serial_bit = value_sr[VALUE_W-1];
    ctrl.load_hex   = (in_mode != MODE_DEC);

    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          // Hex nibbles go straight into the cells; decimal starts from zero.
          ctrl.op       = OP_LOAD;
          value_sr_next = in_value;
          bit_cnt_next  = '0;
          upper_next    = (in_mode != MODE_DEC) && (in_mode != MODE_LHEX);
          pad_char_next = in_pad_zero ? CHAR_ZERO : CHAR_SPACE;
          width_next    = (in_width > FIELD7_W'(MAX_CHARS)) ? CW'(MAX_CHARS)
                                                          : in_width[CW-1:0];
          room_next     = (in_room > FIELD7_W'(MAX_CHARS)) ? CW'(MAX_CHARS)
                                                         : in_room[CW-1:0];
          ndig_next     = DW'(MAX_DIGITS);
          ovf_next      = 1'b0;
          state_next    = (in_mode == MODE_DEC) ? S_DABBLE : S_NORM;
        end
      end
      S_DABBLE: begin
        // One value bit per cycle, most significant first. A carry out of the
        // top cell means the value has more digits than the row holds.
        ctrl.op       = OP_DABBLE;
        value_sr_next = {value_sr[VALUE_W-2:0], 1'b0};
        bit_cnt_next  = bit_cnt + 1'b1;
        if (stat.top_carry) begin
          ovf_next = 1'b1;
        end
        if (bit_cnt == BW'(VALUE_W - 1)) begin
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        // Strip leading zeros, keeping at least one digit. An overflowed
        // conversion keeps the full row.
        if (!ovf && (ndig > DW'(1)) && (stat.top_digit == 4'd0)) begin
          ctrl.op   = OP_SHIFT;
          ndig_next = ndig - 1'b1;
        end else begin
          state_next = S_PLAN;
        end
      end
      S_PLAN: begin
        pads_left_next  = pads_n;
        shown_left_next = shown_n;
        state_next      = (room == '0) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          if (pads_left != '0) begin
            out_char_next  = pad_char;
            out_last_next  = (pads_left == CW'(1)) && (shown_left == '0);
            pads_left_next = pads_left - 1'b1;
            if (out_last_next) begin
              state_next = S_IDLE;
            end
          end else begin
            // The top cell holds the next digit; the row moves up behind it.
            ctrl.op         = OP_SHIFT;
            out_char_next   = digit_char(stat.top_digit, upper);
            out_last_next   = (shown_left == DW'(1));
            shown_left_next = shown_left - 1'b1;
            if (out_last_next) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      ndig       <= DW'(1);
      ovf        <= 1'b0;
      pads_left  <= '0;
      shown_left <= '0;
      bit_cnt    <= '0;
    end else begin
      state      <= state_next;
      out_valid  <= out_valid_next;
      ndig       <= ndig_next;
      ovf        <= ovf_next;
      pads_left  <= pads_left_next;
      shown_left <= shown_left_next;
      bit_cnt    <= bit_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    value_sr <= value_sr_next;
    upper    <= upper_next;
    pad_char <= pad_char_next;
    width    <= width_next;
    room     <= room_next;
    out_char <= out_char_next;
    out_last <= out_last_next;
  end

`include "integer_to_ascii_padded_top_assert.svh"

  // While characters are being emitted there is always at least one left.
  `I2AP_ASSERT_NOW(a_emit_has_work, clk, rst, state == S_EMIT,
                   (pads_left != '0) || (shown_left != '0))
  // An item in flight always has between one and MAX_DIGITS digits.
  `I2AP_ASSERT_NOW(a_ndig_range, clk, rst, state != S_IDLE,
                   (ndig != '0) && (ndig <= DW'(MAX_DIGITS)))
  // The last conversion step hands over to the zero stripping.
  `I2AP_ASSERT_NEXT(a_dabble_done, clk, rst,
                    (state == S_DABBLE) && (bit_cnt == BW'(VALUE_W - 1)), state == S_NORM)
  // An accepted beat always leaves idle.
  `I2AP_ASSERT_NEXT(a_accept_busy, clk, rst, s_axis_tvalid && s_axis_tready,
                    !s_axis_tready)

endmodule

`default_nettype wire

// File: design/i2ap_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One digit position: a BCD double-dabble stage that can also load a hex
// nibble or take its lower neighbor's digit.
module i2ap_cell
  import i2ap_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_op_t   op,
  input  wire logic [3:0] load_nib,
  input  wire logic [3:0] lower_digit,
  input  wire logic       lower_carry,
  output logic      [3:0] digit,
  output logic            carry
);

  logic [3:0] adj;
  logic [3:0] digit_next;

  always_comb begin
    adj   = (digit >= 4'd5) ? digit + 4'd3 : digit;
    carry = adj[3];
  end

  always_comb begin
    unique case (op)
      OP_LOAD:   digit_next = load_nib;
      OP_DABBLE: digit_next = {adj[2:0], lower_carry};
      OP_SHIFT:  digit_next = lower_digit;
      default:   digit_next = digit;
    endcase
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

`default_nettype wire

// File: design/i2ap_chain.sv
`timescale 1ns / 1ps
`default_nettype none

// Row of digit cells; cell 0 is the least significant digit.
module i2ap_chain
  import i2ap_pkg::*;
#(
  parameter int N_DIGITS = 20
) (
  input  wire logic               clk,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic [VALUE_W-1:0] value,
  output chain_stat_t             stat
);

  logic [3:0] digits [N_DIGITS];
  logic       carries [N_DIGITS];

  for (genvar i = 0; i < N_DIGITS; i++) begin : g_cell
    logic [3:0] nib;
    logic [3:0] lower_digit;
    logic       lower_carry;

    if (i < NIBBLES) begin : g_nib
      assign nib = ctrl.load_hex ? value[4*i +: 4] : 4'd0;
    end else begin : g_zero
      assign nib = 4'd0;
    end

    if (i == 0) begin : g_first
      assign lower_digit = 4'd0;
      assign lower_carry = ctrl.serial_bit;
    end else begin : g_rest
      assign lower_digit = digits[i-1];
      assign lower_carry = carries[i-1];
    end

    i2ap_cell u_cell (
      .clk         (clk),
      .op          (ctrl.op),
      .load_nib    (nib),
      .lower_digit (lower_digit),
      .lower_carry (lower_carry),
      .digit       (digits[i]),
      .carry       (carries[i])
    );
  end

  assign stat.top_digit = digits[N_DIGITS-1];
  assign stat.top_carry = carries[N_DIGITS-1];

endmodule

`default_nettype wire
